### rtl/dlaq_pkg.sv
// shared constants and codes of the delta list alarm queue
package dlaq_pkg;

  localparam int unsigned SLOTS    = 32;
  localparam int unsigned MAX_FIRE = 10;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned FIRE_W   = $clog2(MAX_FIRE + 1);
  localparam int unsigned DELTA_W  = 32;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned ID_W     = 5;

  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_UNDEF  = 2'd3;

  localparam logic [2:0] KIND_SET_OK   = 3'd0;
  localparam logic [2:0] KIND_FULL     = 3'd1;
  localparam logic [2:0] KIND_CANCEL   = 3'd2;
  localparam logic [2:0] KIND_EXPIRED  = 3'd3;
  localparam logic [2:0] KIND_EXP_CANC = 3'd4;
  localparam logic [2:0] KIND_NONE_DUE = 3'd5;

endpackage

### rtl/dlaq_alu.sv
// shared subtract and signed compare unit
module dlaq_alu import dlaq_pkg::*; (
  input  logic [DELTA_W-1:0] a_i,
  input  logic [DELTA_W-1:0] b_i,
  output logic [DELTA_W-1:0] diff_o,
  output logic               ge_o
);

  assign diff_o = a_i - b_i;
  assign ge_o   = $signed(a_i) >= $signed(b_i);

endmodule

### rtl/delta_list_alarm_queue.sv
// delta list alarm queue: sequencer, slot stores and stream ports
// set: free slot scan beside the list walk, then fix and link, then the output
// tick: fires due head entries, up to MAX_FIRE, then one output per fired entry
// cancel: marks the slot, then the output; one item at a time, taken only in idle
// reset clears busy and cancel marks and empties the list; no clearing pass
module delta_list_alarm_queue import dlaq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // cmd[1:0], delay_ticks[17:2], tag[49:18], slot[54:50]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // slot_id[4:0], tag_out[36:5]
  output logic [2:0]  m_axis_tuser,   // kind[2:0]
  output logic        m_axis_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SET, ST_FIX, ST_LINK, ST_TICK, ST_DEC, ST_EMIT, ST_OUT
  } state_e;

  state_e state_q;

  logic [DELTA_W-1:0] delta_mem [SLOTS];
  logic [SLOT_W-1:0]  next_mem  [SLOTS];
  logic               nv_mem    [SLOTS];
  logic [TAG_W-1:0]   tag_mem   [SLOTS];

  logic [SLOTS-1:0]   busy_q, canc_q;
  logic [SLOT_W-1:0]  head_q, w_q, pw_q, s_q, scan_q;
  logic               empty_q, found_q, walk_q, prev_q, brk_q;
  logic [DELTA_W-1:0] d_q;
  logic [TAG_W-1:0]   tag_in_q;
  logic [FIRE_W-1:0]  n_q, e_q;
  logic [SLOT_W-1:0]  fired_q [MAX_FIRE];

  logic               out_valid_q, out_last_q;
  logic [2:0]         out_kind_q;
  logic [ID_W-1:0]    out_id_q;
  logic [TAG_W-1:0]   out_tag_q;

  logic [1:0]         in_cmd;
  logic [15:0]        in_delay;
  logic [TAG_W-1:0]   in_tag;
  logic [4:0]         in_slot;
  logic [SLOT_W-1:0]  in_sidx;

  logic [SLOT_W-1:0]  d_addr, l_addr, f_slot;
  logic [DELTA_W-1:0] d_rd, alu_a, alu_b, alu_diff;
  logic               alu_ge;

  assign in_cmd   = s_axis_tdata[1:0];
  assign in_delay = s_axis_tdata[17:2];
  assign in_tag   = s_axis_tdata[49:18];
  assign in_slot  = s_axis_tdata[54:50];
  assign in_sidx  = SLOT_W'(in_slot);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_tag_q, out_id_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  assign d_addr = (state_q == ST_TICK || state_q == ST_DEC) ? head_q : w_q;
  assign l_addr = (state_q == ST_TICK) ? head_q : ((state_q == ST_LINK) ? pw_q : w_q);
  assign d_rd   = delta_mem[d_addr];
  assign f_slot = fired_q[e_q[$clog2(MAX_FIRE > 1 ? MAX_FIRE : 2)-1:0]];

  always_comb begin
    case (state_q)
      ST_SET: begin
        alu_a = d_q;
        alu_b = d_rd;
      end
      ST_TICK: begin
        alu_a = '0;
        alu_b = d_rd;
      end
      ST_DEC: begin
        alu_a = d_rd;
        alu_b = DELTA_W'(1);
      end
      default: begin
        alu_a = d_rd;
        alu_b = d_q;
      end
    endcase
  end

  dlaq_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  // slot stores
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIX && brk_q) begin
      delta_mem[w_q] <= alu_diff;
    end
    if (state_q == ST_DEC && !empty_q) begin
      delta_mem[head_q] <= alu_diff;
    end
    if (state_q == ST_LINK) begin
      delta_mem[s_q] <= d_q;
      tag_mem[s_q]   <= tag_in_q;
      if (prev_q) begin
        nv_mem[s_q]    <= nv_mem[l_addr];
        next_mem[s_q]  <= next_mem[l_addr];
        next_mem[pw_q] <= s_q;
        nv_mem[pw_q]   <= 1'b1;
      end else begin
        nv_mem[s_q]   <= !empty_q;
        next_mem[s_q] <= head_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= '0;
      canc_q      <= '0;
      head_q      <= '0;
      empty_q     <= 1'b1;
      found_q     <= 1'b0;
      walk_q      <= 1'b0;
      prev_q      <= 1'b0;
      brk_q       <= 1'b0;
      scan_q      <= '0;
      w_q         <= '0;
      pw_q        <= '0;
      s_q         <= '0;
      d_q         <= '0;
      tag_in_q    <= '0;
      n_q         <= '0;
      e_q         <= '0;
      fired_q     <= '{default: '0};
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_kind_q  <= KIND_SET_OK;
      out_id_q    <= '0;
      out_tag_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          n_q <= '0;
          e_q <= '0;
          if (s_axis_tvalid) begin
            case (in_cmd)
              CMD_SET: begin
                d_q      <= DELTA_W'(in_delay);
                tag_in_q <= in_tag;
                w_q      <= head_q;
                walk_q   <= !empty_q;
                prev_q   <= 1'b0;
                brk_q    <= 1'b0;
                found_q  <= 1'b0;
                scan_q   <= '0;
                state_q  <= ST_SET;
              end
              CMD_CANCEL: begin
                if (busy_q[in_sidx]) begin
                  canc_q[in_sidx] <= 1'b1;
                end
                out_kind_q  <= KIND_CANCEL;
                out_id_q    <= in_slot;
                out_tag_q   <= '0;
                out_last_q  <= 1'b1;
                out_valid_q <= 1'b1;
                state_q     <= ST_OUT;
              end
              CMD_TICK: begin
                state_q <= ST_TICK;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SET: begin
          if (walk_q) begin
            if (alu_ge) begin
              d_q    <= alu_diff;
              pw_q   <= w_q;
              prev_q <= 1'b1;
              walk_q <= nv_mem[l_addr];
              w_q    <= next_mem[l_addr];
            end else begin
              brk_q  <= 1'b1;
              walk_q <= 1'b0;
            end
          end
          if (!found_q) begin
            if (!busy_q[scan_q]) begin
              found_q <= 1'b1;
              s_q     <= scan_q;
            end else if (scan_q == SLOT_W'(SLOTS - 1)) begin
              out_kind_q  <= KIND_FULL;
              out_id_q    <= '0;
              out_tag_q   <= '0;
              out_last_q  <= 1'b1;
              out_valid_q <= 1'b1;
              state_q     <= ST_OUT;
            end else begin
              scan_q <= scan_q + SLOT_W'(1);
            end
          end else if (!walk_q) begin
            state_q <= ST_FIX;
          end
        end
        ST_FIX: begin
          state_q <= ST_LINK;
        end
        ST_LINK: begin
          busy_q[s_q] <= 1'b1;
          canc_q[s_q] <= 1'b0;
          if (!prev_q) begin
            head_q  <= s_q;
            empty_q <= 1'b0;
          end
          out_kind_q  <= KIND_SET_OK;
          out_id_q    <= ID_W'(s_q);
          out_tag_q   <= '0;
          out_last_q  <= 1'b1;
          out_valid_q <= 1'b1;
          state_q     <= ST_OUT;
        end
        ST_TICK: begin
          if (!empty_q && n_q < FIRE_W'(MAX_FIRE) && alu_ge) begin
            fired_q[n_q[$clog2(MAX_FIRE > 1 ? MAX_FIRE : 2)-1:0]] <= head_q;
            n_q <= n_q + FIRE_W'(1);
            if (nv_mem[l_addr]) begin
              head_q <= next_mem[l_addr];
            end else begin
              empty_q <= 1'b1;
            end
          end else begin
            state_q <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (n_q == '0) begin
            out_kind_q  <= KIND_NONE_DUE;
            out_id_q    <= '0;
            out_tag_q   <= '0;
            out_last_q  <= 1'b1;
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          out_kind_q  <= canc_q[f_slot] ? KIND_EXP_CANC : KIND_EXPIRED;
          out_id_q    <= ID_W'(f_slot);
          out_tag_q   <= tag_mem[f_slot];
          out_last_q  <= (e_q + FIRE_W'(1)) == n_q;
          out_valid_q <= 1'b1;
          busy_q[f_slot] <= 1'b0;
          canc_q[f_slot] <= 1'b0;
          e_q         <= e_q + FIRE_W'(1);
          state_q     <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            out_valid_q <= 1'b0;
            state_q     <= (e_q != n_q) ? ST_EMIT : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### sim/dlaq_checker.sv
// checker: watches both streams, predicts alarm queue results and compares them
`timescale 1ns / 100ps

module dlaq_checker import dlaq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o,
  output int          fired_count_o,
  output int          full_count_o
);

  typedef struct packed {
    logic [2:0]       kind;
    logic [ID_W-1:0]  slot_id;
    logic [TAG_W-1:0] tag_out;
    logic             last;
  } alarm_result_t;

  logic [DELTA_W-1:0] q_delta [SLOTS];
  logic [SLOT_W-1:0]  q_next  [SLOTS];
  logic               q_nval  [SLOTS];
  logic [TAG_W-1:0]   q_tag   [SLOTS];
  logic               q_busy  [SLOTS];
  logic               q_canc  [SLOTS];
  logic [SLOT_W-1:0]  q_head;
  logic               q_empty;

  alarm_result_t due_results[$];

  assign pending_o = due_results.size();

  function automatic alarm_result_t mk(logic [2:0] k, logic [ID_W-1:0] s,
                                       logic [TAG_W-1:0] t, logic l);
    alarm_result_t r;
    r.kind = k; r.slot_id = s; r.tag_out = t; r.last = l;
    return r;
  endfunction

  task automatic predict_set(logic [15:0] dly, logic [TAG_W-1:0] tg);
    int s;
    int w;
    int pw;
    bit have_prev;
    bit have_w;
    logic signed [DELTA_W-1:0] d;
    s = -1;
    pw = 0;
    have_prev = 0;
    for (int i = SLOTS - 1; i >= 0; i--) if (!q_busy[i]) s = i;
    if (s < 0) begin
      due_results.push_back(mk(KIND_FULL, '0, '0, 1'b1));
      full_count_o++;
      return;
    end
    q_busy[s] = 1; q_canc[s] = 0; q_tag[s] = tg;
    d = {16'h0, dly};
    have_w = !q_empty;
    w = q_head;
    for (int st = 0; have_w && st < SLOTS; st++) begin
      if ($signed(q_delta[w]) <= d) begin
        d = d - $signed(q_delta[w]);
        pw = w; have_prev = 1;
        have_w = q_nval[w];
        w = q_next[w];
      end else begin
        q_delta[w] = q_delta[w] - d;
        break;
      end
    end
    q_delta[s] = d;
    if (have_prev) begin
      q_nval[s] = q_nval[pw]; q_next[s] = q_next[pw];
      q_next[pw] = SLOT_W'(s); q_nval[pw] = 1;
    end else begin
      q_nval[s] = !q_empty; q_next[s] = q_head;
      q_head = SLOT_W'(s); q_empty = 0;
    end
    due_results.push_back(mk(KIND_SET_OK, ID_W'(s), '0, 1'b1));
  endtask

  task automatic predict_tick();
    int n;
    int h;
    int fired[MAX_FIRE];
    n = 0;
    while (!q_empty && n < MAX_FIRE) begin
      h = q_head;
      if ($signed(q_delta[h]) > 0) break;
      fired[n++] = h;
      if (q_nval[h]) q_head = q_next[h];
      else q_empty = 1;
    end
    if (!q_empty) q_delta[q_head] = q_delta[q_head] - 1;
    if (n == 0) begin
      due_results.push_back(mk(KIND_NONE_DUE, '0, '0, 1'b1));
      return;
    end
    for (int i = 0; i < n; i++) begin
      due_results.push_back(mk(q_canc[fired[i]] ? KIND_EXP_CANC : KIND_EXPIRED,
                               ID_W'(fired[i]), q_tag[fired[i]], i == n - 1));
      q_busy[fired[i]] = 0; q_canc[fired[i]] = 0;
      fired_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alarm_result_t got;
    alarm_result_t want;
    logic [1:0] cmd;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        q_busy[i] = 0; q_canc[i] = 0;
      end
      q_head = '0; q_empty = 1;
      due_results.delete();
      fail_count_o = 0; fired_count_o = 0; full_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = mk(m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[36:5], m_axis_tlast);
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d slot=%0d tag=%h last=%0b", $time,
                   got.kind, got.slot_id, got.tag_out, got.last);
          fail_count_o++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected kind=%0d slot=%0d tag=%h last=%0b", $time,
                     want.kind, want.slot_id, want.tag_out, want.last);
            $display("%0t:          actual   kind=%0d slot=%0d tag=%h last=%0b", $time,
                     got.kind, got.slot_id, got.tag_out, got.last);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cmd = s_axis_tdata[1:0];
        case (cmd)
          CMD_SET: predict_set(s_axis_tdata[17:2], s_axis_tdata[49:18]);
          CMD_CANCEL: begin
            if (q_busy[s_axis_tdata[54:50]]) q_canc[s_axis_tdata[54:50]] = 1;
            due_results.push_back(mk(KIND_CANCEL, s_axis_tdata[54:50], '0, 1'b1));
          end
          CMD_TICK: predict_tick();
          default: ;
        endcase
      end
    end
  end

endmodule

### sim/testbench.sv
// testbench top: drives commands into the alarm queue, stalls the output, gives the verdict
`timescale 1ns / 100ps

module testbench import dlaq_pkg::*;;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;
  int          fired_count;
  int          full_count;
  int          idle_cycles = 0;
  int          items_sent = 0;
  bit          hold_off = 0;

  always #5 clk_i = ~clk_i;

  delta_list_alarm_queue u_top (.*);

  dlaq_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending),
    .fired_count_o(fired_count), .full_count_o(full_count)
  );

  task automatic send_item(logic [1:0] cmd, logic [15:0] dly, logic [31:0] tg,
                           logic [4:0] sl);
    repeat ($urandom_range(0, 6)) @(negedge clk_i);
    s_axis_tdata  <= {1'b0, sl, tg, dly, cmd};
    s_axis_tvalid <= 1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid <= 0;
    items_sent++;
  endtask

  function automatic logic [15:0] rand_delay();
    case ($urandom_range(0, 9))
      0: return 16'hFFFF;
      1: return 16'h0;
      2, 3: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 12));
    endcase
  endfunction

  // receiver: random wait per item, one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (400) @(negedge clk_i);
        hold_off = 0;
      end
      m_axis_tready <= 0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      m_axis_tready <= 1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    // directed: extremes, every command, special cases
    send_item(CMD_TICK, 16'h0, 32'h0, 5'd0);
    send_item(CMD_CANCEL, 16'h0, 32'h0, 5'd31);
    send_item(CMD_SET, 16'h0, 32'hFFFFFFFF, 5'd0);
    send_item(CMD_SET, 16'hFFFF, 32'h0, 5'd31);
    send_item(CMD_SET, 16'd3, 32'hA5A5A5A5, 5'd0);
    send_item(CMD_SET, 16'd3, 32'h5A5A5A5A, 5'd0);
    send_item(CMD_CANCEL, 16'hFFFF, 32'hFFFFFFFF, 5'd3);
    send_item(CMD_CANCEL, 16'h0, 32'h0, 5'd3);
    send_item(CMD_UNDEF, 16'hFFFF, 32'hFFFFFFFF, 5'd31);
    repeat (5) send_item(CMD_TICK, 16'hFFFF, 32'hFFFFFFFF, 5'd31);
    for (int i = 0; i < 12; i++) send_item(CMD_SET, 16'd0, 32'h1000 + i, 5'd0);
    send_item(CMD_TICK, 16'h0, 32'h0, 5'd0);
    send_item(CMD_TICK, 16'h0, 32'h0, 5'd0);
    // random: mostly sets and ticks, with a fill-up burst
    hold_off = 1;
    for (int n = 0; n < 290; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_item(CMD_SET, rand_delay(), $urandom, 5'($urandom_range(0, 31)));
        4: send_item(CMD_CANCEL, 16'($urandom), $urandom, 5'($urandom_range(0, 31)));
        5: send_item(CMD_UNDEF, 16'($urandom), $urandom, 5'($urandom_range(0, 31)));
        default: send_item(CMD_TICK, 16'($urandom), $urandom, 5'($urandom_range(0, 31)));
      endcase
      if (n == 150)
        for (int k = 0; k < 36; k++) send_item(CMD_SET, 16'd5, $urandom, 5'd0);
    end
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("sent %0d items; %0d alarms fired, %0d pool-full refusals", items_sent,
             fired_count, full_count);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
